### sv/bpc_pkg.sv
// Shared types and constants for the balance controller.
// No dependencies; compiled first.
package bpc_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam int MUL_W      = 33;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int FRAC_SHIFT = 20;

   // reciprocal of five for exact floor division of a 32 bit magnitude
   localparam logic [31:0] DIV5_MAGIC = 32'hCCCC_CCCD;
   localparam int          DIV5_SHIFT = 34;

   localparam logic signed [15:0] ZERO_ANGLE_RST  = 16'sd1024;
   localparam logic        [15:0] BAL_P_GAIN_RST  = 16'd24576;
   localparam logic        [15:0] BAL_D_GAIN_RST  = 16'd3686;
   localparam logic        [15:0] VEL_P_GAIN_RST  = 16'd16384;
   localparam logic        [15:0] VEL_I_GAIN_RST  = 16'd82;
   localparam logic        [19:0] INT_LIMIT_RST   = 20'd10000;
   localparam logic        [6:0]  OUT_LIMIT_RST   = 7'd98;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ZERO_ANGLE = 3'd0,
      CSR_BAL_P_GAIN = 3'd1,
      CSR_BAL_D_GAIN = 3'd2,
      CSR_VEL_P_GAIN = 3'd3,
      CSR_VEL_I_GAIN = 3'd4,
      CSR_INT_LIMIT  = 3'd5,
      CSR_OUT_LIMIT  = 3'd6
   } bpc_csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BAL_P,
      ST_BAL_D,
      ST_DIV,
      ST_FILT,
      ST_INTEG,
      ST_VEL_I,
      ST_SUM,
      ST_DRIVE,
      ST_OUT
   } bpc_state_type;

   typedef enum logic [1:0] {
      MAC_HOLD,
      MAC_LOAD,
      MAC_ACC,
      MAC_LOAD_SUB
   } bpc_mac_op_type;

   typedef struct packed {
      logic           prod_en;
      bpc_mac_op_type op;
   } bpc_mac_ctrl_type;

endpackage

### sv/bpc_req_if.sv
// Request channel: one control tick per beat.
// No dependencies.
interface bpc_req_if;
   logic               valid;
   logic               ready;
   logic               manual;
   logic signed [7:0]  stick_speed;
   logic signed [15:0] tilt_angle;
   logic signed [15:0] tilt_rate;
   logic signed [15:0] count_left;
   logic signed [15:0] count_right;

   modport source (output valid, output manual, output stick_speed, output tilt_angle,
                   output tilt_rate, output count_left, output count_right, input ready);
   modport sink   (input valid, input manual, input stick_speed, input tilt_angle,
                   input tilt_rate, input count_left, input count_right, output ready);
endinterface

### sv/bpc_rsp_if.sv
// Response channel: bridge duties, one beat per tick.
// No dependencies.
interface bpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] forward_duty;
   logic [6:0] reverse_duty;

   modport source (output valid, output forward_duty, output reverse_duty, input ready);
   modport sink   (input valid, input forward_duty, input reverse_duty, output ready);
endinterface

### sv/balance_robot_pd_pi_controller_unit.sv
// Balance robot PD balance / PI velocity controller, top level.
// A manual tick goes straight from the request beat to the offered result; an automatic
//   tick steps through the sequencer states; five products share the single multiplier.
// One tick at a time: the next request is taken the cycle after the result is taken.
// Synchronous reset restores registers to defaults and clears loop state.
module balance_robot_pd_pi_controller_unit (
   input  logic                                clock,
   input  logic                                reset,
   bpc_req_if.sink                             req_bus,
   bpc_rsp_if.source                           rsp_bus,
   input  logic                                csr_we,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import bpc_pkg::*;

   // control and status registers
   logic signed [15:0] zero_angle_ff;
   logic        [15:0] bal_p_ff;
   logic        [15:0] bal_d_ff;
   logic        [15:0] vel_p_ff;
   logic        [15:0] vel_i_ff;
   logic        [19:0] int_lim_ff;
   logic        [6:0]  out_lim_ff;

   // sequencer and loop state
   bpc_state_type      state_ff, state_in;
   logic               first_ff, first_in;
   logic signed [31:0] filt_ff, filt_in;
   logic signed [31:0] disp_ff, disp_in;

   // per-tick operands and intermediates
   logic signed [15:0] angle_ff, angle_in;
   logic signed [15:0] rate_ff, rate_in;
   logic signed [16:0] csum_ff, csum_in;
   logic               div_neg_ff, div_neg_in;
   logic signed [15:0] bal_ff, bal_in;
   logic signed [7:0]  drive_ff, drive_in;

   // shared multiplier
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] sub_val;
   logic signed [PROD_W-1:0] prod_ff, acc_ff;
   bpc_mac_ctrl_type         mac_ctrl;

   // helper terms
   logic signed [14:0]       man_prod;
   logic signed [7:0]        man_drive;
   logic signed [34:0]       sum4;
   logic        [34:0]       sum4_mag;
   logic        [31:0]       quot;
   logic signed [PROD_W-1:0] acc_bias;
   logic signed [PROD_W-1:0] acc_shr;
   logic signed [32:0]       integ;
   logic signed [33:0]       lim;
   logic signed [PROD_W-1:0] olim;

   bpc_mac u_mac (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .sub_val (sub_val),
      .ctrl    (mac_ctrl),
      .prod_ff (prod_ff),
      .acc_ff  (acc_ff)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_angle_ff <= ZERO_ANGLE_RST;
         bal_p_ff      <= BAL_P_GAIN_RST;
         bal_d_ff      <= BAL_D_GAIN_RST;
         vel_p_ff      <= VEL_P_GAIN_RST;
         vel_i_ff      <= VEL_I_GAIN_RST;
         int_lim_ff    <= INT_LIMIT_RST;
         out_lim_ff    <= OUT_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ZERO_ANGLE: zero_angle_ff <= csr_wdata[15:0];
            CSR_BAL_P_GAIN: bal_p_ff      <= csr_wdata[15:0];
            CSR_BAL_D_GAIN: bal_d_ff      <= csr_wdata[15:0];
            CSR_VEL_P_GAIN: vel_p_ff      <= csr_wdata[15:0];
            CSR_VEL_I_GAIN: vel_i_ff      <= csr_wdata[15:0];
            CSR_INT_LIMIT:  int_lim_ff    <= csr_wdata;
            CSR_OUT_LIMIT:  out_lim_ff    <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // manual drive: 100*speed/128 rounded toward zero
   assign man_prod  = 15'(req_bus.stick_speed) * 15'sd100;
   assign man_drive = 8'((man_prod + (man_prod < 0 ? 15'sd127 : 15'sd0)) >>> 7);

   // filter numerator 4*f + 256*S; magnitude fits 32 bits by the filter's bound
   assign sum4     = (35'(filt_ff) <<< 2) + (35'(csum_ff) <<< 8);
   assign sum4_mag = sum4 < 0 ? 35'(-sum4) : 35'(sum4);
   assign quot     = prod_ff[DIV5_SHIFT+31:DIV5_SHIFT];

   // accumulator divided by 2^20, rounded toward zero
   assign acc_bias = acc_ff < 0 ? PROD_W'((1 << FRAC_SHIFT) - 1) : '0;
   assign acc_shr  = (acc_ff + acc_bias) >>> FRAC_SHIFT;

   // integral update and clamp
   assign integ = 33'(disp_ff) + 33'(filt_ff);
   assign lim   = $signed({6'b0, int_lim_ff, 8'b0});
   assign olim  = $signed(PROD_W'(out_lim_ff));

   assign sub_val = PROD_W'(bal_ff) <<< FRAC_SHIFT;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      first_in     = first_ff;
      filt_in      = filt_ff;
      disp_in      = disp_ff;
      angle_in     = angle_ff;
      rate_in      = rate_ff;
      csum_in      = csum_ff;
      div_neg_in   = div_neg_ff;
      bal_in       = bal_ff;
      drive_in     = drive_ff;
      mul_a        = '0;
      mul_b        = '0;
      mac_ctrl     = '{prod_en: 1'b0, op: MAC_HOLD};
      req_bus.ready = (state_ff == ST_IDLE);
      rsp_bus.valid = (state_ff == ST_OUT);

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               angle_in = req_bus.tilt_angle;
               rate_in  = req_bus.tilt_rate;
               csum_in  = 17'(req_bus.count_left) + 17'(req_bus.count_right);
               if (req_bus.manual) begin
                  drive_in = man_drive;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_BAL_P;
               end
            end
         end
         ST_BAL_P: begin
            // p * (angle - set-point)
            mul_a    = $signed({17'b0, bal_p_ff});
            mul_b    = MUL_W'(17'(angle_ff) - 17'(zero_angle_ff));
            mac_ctrl = '{prod_en: 1'b1, op: MAC_HOLD};
            state_in = ST_BAL_D;
         end
         ST_BAL_D: begin
            mul_a    = $signed({17'b0, bal_d_ff});
            mul_b    = MUL_W'(rate_ff);
            mac_ctrl = '{prod_en: 1'b1, op: MAC_LOAD};
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // |4f + 256S| / 5 via reciprocal; PD numerator completes in acc
            mul_a      = $signed({1'b0, sum4_mag[31:0]});
            mul_b      = $signed({1'b0, DIV5_MAGIC});
            mac_ctrl   = '{prod_en: 1'b1, op: MAC_ACC};
            div_neg_in = sum4 < 0;
            state_in   = ST_FILT;
         end
         ST_FILT: begin
            filt_in  = div_neg_ff ? -$signed(quot) : $signed(quot);
            bal_in   = acc_shr[15:0];
            state_in = ST_INTEG;
         end
         ST_INTEG: begin
            if (34'(integ) > lim)
               disp_in = lim[31:0];
            else if (34'(integ) < -lim)
               disp_in = 32'(-lim);
            else
               disp_in = integ[31:0];
            mul_a    = MUL_W'(filt_ff);
            mul_b    = $signed({17'b0, vel_p_ff});
            mac_ctrl = '{prod_en: 1'b1, op: MAC_HOLD};
            if (first_ff) begin
               // first automatic tick: state updated, drive held at zero
               first_in = 1'b0;
               drive_in = '0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_VEL_I;
            end
         end
         ST_VEL_I: begin
            mul_a    = MUL_W'(disp_ff);
            mul_b    = $signed({17'b0, vel_i_ff});
            mac_ctrl = '{prod_en: 1'b1, op: MAC_LOAD_SUB};
            state_in = ST_SUM;
         end
         ST_SUM: begin
            mac_ctrl = '{prod_en: 1'b0, op: MAC_ACC};
            state_in = ST_DRIVE;
         end
         ST_DRIVE: begin
            if (acc_shr > olim)
               drive_in = 8'(olim);
            else if (acc_shr < -olim)
               drive_in = 8'(-olim);
            else
               drive_in = acc_shr[7:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_bus.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         first_ff <= 1'b1;
         filt_ff  <= '0;
         disp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
         filt_ff  <= filt_in;
         disp_ff  <= disp_in;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff   <= angle_in;
      rate_ff    <= rate_in;
      csum_ff    <= csum_in;
      div_neg_ff <= div_neg_in;
      bal_ff     <= bal_in;
      drive_ff   <= drive_in;
   end

   // split signed drive into bridge legs
   assign rsp_bus.forward_duty = drive_ff < 0 ? 7'd0 : drive_ff[6:0];
   assign rsp_bus.reverse_duty = drive_ff < 0 ? 7'(-drive_ff) : 7'd0;

endmodule

### sv/bpc_mac.sv
// Shared 33x33 signed multiplier with product register and accumulator.
// Depends on bpc_pkg.
module bpc_mac (
   input  logic                                   clock,
   input  logic signed [bpc_pkg::MUL_W-1:0]       mul_a,
   input  logic signed [bpc_pkg::MUL_W-1:0]       mul_b,
   input  logic signed [bpc_pkg::PROD_W-1:0]      sub_val,
   input  bpc_pkg::bpc_mac_ctrl_type              ctrl,
   output logic signed [bpc_pkg::PROD_W-1:0]      prod_ff,
   output logic signed [bpc_pkg::PROD_W-1:0]      acc_ff
);
   import bpc_pkg::*;

   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] acc_in;

   always_comb begin
      // full-width signed product: operands extend to the product width
      prod_in = ctrl.prod_en ? mul_a * mul_b : prod_ff;
      case (ctrl.op)
         MAC_LOAD:     acc_in = prod_ff;
         MAC_ACC:      acc_in = acc_ff + prod_ff;
         MAC_LOAD_SUB: acc_in = prod_ff - sub_val;
         default:      acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule

### dv/balance_robot_pd_pi_controller_unit_test.sv
// Self-checking bench for the balance robot PD/PI drive controller.
// Directed table then randomised phases, scored against a local duty model or a pinned duty.
// Needs bpc_pkg, bpc_req_if, bpc_rsp_if and the controller top level.
module balance_robot_pd_pi_controller_unit_test;
   import bpc_pkg::*;

   // Q.20 scale used by both loop terms
   localparam longint Q20_ONE = 64'sd1048576;
   // run ceiling, far beyond the slowest legal run
   localparam longint RUN_LIMIT = 64'd8000000;
   localparam int     PHASES = 10;
   localparam int     TICKS_PER_PHASE = 115;

   typedef struct packed {
      logic               manual;
      logic signed [7:0]  stick_speed;
      logic signed [15:0] tilt_angle;
      logic signed [15:0] tilt_rate;
      logic signed [15:0] count_left;
      logic signed [15:0] count_right;
   } tick_type;

   typedef struct packed {
      logic [6:0] forward_duty;
      logic [6:0] reverse_duty;
   } duty_type;

   typedef enum logic { ROW_TICK, ROW_CSR } row_kind_type;

   typedef struct {
      row_kind_type      kind;
      tick_type          tick;
      logic              pinned;
      duty_type          duty;
      bpc_csr_index_type csr_idx;
      logic [19:0]       csr_val;
   } stim_row_type;

   typedef enum logic [1:0] { RX_OPEN, RX_COIN, RX_COMB } rx_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bpc_req_if req_bus ();
   bpc_rsp_if rsp_bus ();

   balance_robot_pd_pi_controller_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Duty model: register copies and loop state
   logic signed [15:0] cfg_zero_angle;
   logic [15:0]        cfg_bal_p;
   logic [15:0]        cfg_bal_d;
   logic [15:0]        cfg_vel_p;
   logic [15:0]        cfg_vel_i;
   logic [19:0]        cfg_int_limit;
   logic [6:0]         cfg_out_limit;
   int                 filt_q8;
   int                 disp_q8;
   bit                 first_auto;

   duty_type     duty_expected[$];
   stim_row_type stim_table[$];
   int           mismatch_count = 0;
   int           burst_left = 0;

   // typed expectation travelling with a directed beat
   logic     pin_en;
   duty_type pin_duty;

   // receiver stall pattern
   rx_mode_type rx_mode = RX_OPEN;
   int          rx_left = 0;
   int          rx_tick = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   // Signed drive to the pair of bridge duties; magnitude kept to 7 bits.
   function automatic duty_type split_drive(longint drv);
      duty_type d;
      longint   mag;
      mag = -drv;
      if (drv >= 0) begin
         d.forward_duty = drv[6:0];
         d.reverse_duty = 7'd0;
      end else begin
         d.forward_duty = 7'd0;
         d.reverse_duty = mag[6:0];
      end
      return d;
   endfunction

   // Duties for one tick; automatic ticks advance the filter and integral.
   function automatic duty_type predict_duty(tick_type t);
      longint spd, ang, rte, sum, bal, vel, drv, f, integ, lim, olim;
      if (t.manual) begin
         spd = $signed(t.stick_speed);
         return split_drive((100 * spd) / 128);
      end
      ang = $signed(t.tilt_angle);
      rte = $signed(t.tilt_rate);
      sum = longint'($signed(t.count_left)) + longint'($signed(t.count_right));

      // balance term, whole units, truncated toward zero
      bal = (longint'(cfg_bal_p) * (ang - longint'($signed(cfg_zero_angle)))
             + longint'(cfg_bal_d) * rte) / Q20_ONE;

      // 0.8/0.2 low-pass, then clamped integral, 8 fraction bits each
      f = (4 * longint'(filt_q8) + 256 * sum) / 5;
      filt_q8 = int'(f);
      integ = longint'(disp_q8) + f;
      lim = longint'(cfg_int_limit) * 256;
      if (integ > lim) integ = lim;
      if (integ < -lim) integ = -lim;
      disp_q8 = int'(integ);

      // first automatic tick after reset drives nothing
      if (first_auto) begin
         first_auto = 1'b0;
         return split_drive(0);
      end

      vel = f * longint'(cfg_vel_p) + integ * longint'(cfg_vel_i);
      drv = (vel - bal * Q20_ONE) / Q20_ONE;
      olim = longint'(cfg_out_limit);
      if (drv > olim) drv = olim;
      if (drv < -olim) drv = -olim;
      return split_drive(drv);
   endfunction

   task automatic log_mismatch(string what, duty_type want, duty_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("MISMATCH %s: expected fwd %0d rev %0d, got fwd %0d rev %0d",
                  what, want.forward_duty, want.reverse_duty,
                  got.forward_duty, got.reverse_duty);
   endtask

   // Scoreboard. Result beats are scored before the request beat of the same
   // edge is modelled, so a stray result can never meet a fresh expectation.
   always @(posedge clock) begin : scoreboard
      duty_type got;
      duty_type want;
      duty_type calc;
      tick_type beat;
      if (reset) begin
         cfg_zero_angle = ZERO_ANGLE_RST;
         cfg_bal_p      = BAL_P_GAIN_RST;
         cfg_bal_d      = BAL_D_GAIN_RST;
         cfg_vel_p      = VEL_P_GAIN_RST;
         cfg_vel_i      = VEL_I_GAIN_RST;
         cfg_int_limit  = INT_LIMIT_RST;
         cfg_out_limit  = OUT_LIMIT_RST;
         filt_q8        = 0;
         disp_q8        = 0;
         first_auto     = 1'b1;
         duty_expected.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.forward_duty = rsp_bus.forward_duty;
            got.reverse_duty = rsp_bus.reverse_duty;
            if (duty_expected.size() == 0) begin
               log_mismatch("unexpected beat", '0, got);
            end else begin
               want = duty_expected.pop_front();
               if (got.forward_duty !== want.forward_duty ||
                   got.reverse_duty !== want.reverse_duty)
                  log_mismatch("duty", want, got);
            end
         end
         if (csr_we) begin
            case (bpc_csr_index_type'(csr_index))
               CSR_ZERO_ANGLE: cfg_zero_angle = csr_wdata[15:0];
               CSR_BAL_P_GAIN: cfg_bal_p      = csr_wdata[15:0];
               CSR_BAL_D_GAIN: cfg_bal_d      = csr_wdata[15:0];
               CSR_VEL_P_GAIN: cfg_vel_p      = csr_wdata[15:0];
               CSR_VEL_I_GAIN: cfg_vel_i      = csr_wdata[15:0];
               CSR_INT_LIMIT:  cfg_int_limit  = csr_wdata[19:0];
               CSR_OUT_LIMIT:  cfg_out_limit  = csr_wdata[6:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            beat.manual      = req_bus.manual;
            beat.stick_speed = req_bus.stick_speed;
            beat.tilt_angle  = req_bus.tilt_angle;
            beat.tilt_rate   = req_bus.tilt_rate;
            beat.count_left  = req_bus.count_left;
            beat.count_right = req_bus.count_right;
            // model always runs so loop state stays in step with pinned rows
            calc = predict_duty(beat);
            duty_expected.push_back(pin_en ? pin_duty : calc);
         end
      end
   end

   // Receiver: switches between wide open, coin toss and a fixed comb.
   always @(posedge clock) begin
      rx_tick <= rx_tick + 1;
      if (rx_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 2));
         rx_left <= $urandom_range(20, 200);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_mode)
         RX_OPEN: rsp_bus.ready <= 1'b1;
         RX_COIN: rsp_bus.ready <= ($urandom_range(0, 99) < 40);
         default: rsp_bus.ready <= ((rx_tick % 7) > 2);
      endcase
   end

   // One request beat; the sender runs in bursts with random gaps between.
   task automatic send_tick(tick_type t, logic pinned, duty_type pd);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.manual      <= t.manual;
      req_bus.stick_speed <= t.stick_speed;
      req_bus.tilt_angle  <= t.tilt_angle;
      req_bus.tilt_rate   <= t.tilt_rate;
      req_bus.count_left  <= t.count_left;
      req_bus.count_right <= t.count_right;
      pin_en              <= pinned;
      pin_duty            <= pd;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Register write, only once the block has drained every result.
   task automatic write_reg(bpc_csr_index_type idx, logic [19:0] val);
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (duty_expected.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic add_tick(int man, int spd, int ang, int rte, int cl, int cr,
                           int pinned, int fwd, int rev);
      stim_row_type r;
      r.kind = ROW_TICK;
      r.tick.manual      = man[0];
      r.tick.stick_speed = 8'(spd);
      r.tick.tilt_angle  = 16'(ang);
      r.tick.tilt_rate   = 16'(rte);
      r.tick.count_left  = 16'(cl);
      r.tick.count_right = 16'(cr);
      r.pinned = pinned[0];
      r.duty.forward_duty = 7'(fwd);
      r.duty.reverse_duty = 7'(rev);
      r.csr_idx = CSR_ZERO_ANGLE;
      r.csr_val = '0;
      stim_table.push_back(r);
   endtask

   task automatic add_csr(bpc_csr_index_type idx, logic [19:0] val);
      stim_row_type r;
      r.kind = ROW_CSR;
      r.tick = '0;
      r.pinned = 1'b0;
      r.duty = '0;
      r.csr_idx = idx;
      r.csr_val = val;
      stim_table.push_back(r);
   endtask

   task automatic build_table();
      // manual beats first: they must leave the first-tick flag armed
      add_tick(1, 127, 0, 0, 0, 0, 1, 99, 0);
      add_tick(1, -128, 0, 0, 0, 0, 1, 0, 100);
      add_tick(1, -1, 0, 0, 0, 0, 1, 0, 0);
      add_tick(1, 1, 0, 0, 0, 0, 1, 0, 0);
      add_tick(1, 0, 32767, -32768, 32767, -32768, 1, 0, 0);
      // first automatic tick: zero drive, filter still moves
      add_tick(0, 0, -32768, 32767, 100, 100, 1, 0, 0);
      add_tick(0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_tick(0, 0, 32767, 32767, 32767, 32767, 0, 0, 0);
      add_tick(0, 0, -32768, -32768, -32768, -32768, 0, 0, 0);
      add_tick(0, 0, 1024, 0, 0, 0, 0, 0, 0);
      // output limit above 100
      add_csr(CSR_OUT_LIMIT, 20'd127);
      add_tick(0, 0, -32768, -32768, 0, 0, 0, 0, 0);
      add_tick(0, 0, 32767, 32767, 0, 0, 0, 0, 0);
      // zero limit pins the drive at zero; manual ignores it
      add_csr(CSR_OUT_LIMIT, 20'd0);
      add_tick(0, 0, 32767, 32767, 32767, 32767, 1, 0, 0);
      add_tick(1, -128, 0, 0, 0, 0, 1, 0, 100);
      add_csr(CSR_OUT_LIMIT, 20'd100);
      add_csr(CSR_INT_LIMIT, 20'd0);
      add_tick(0, 0, 1024, 0, 32767, 32767, 0, 0, 0);
      add_csr(CSR_INT_LIMIT, 20'hFFFFF);
      add_tick(0, 0, 1024, 0, 32767, 32767, 0, 0, 0);
      add_tick(0, 0, 1024, 0, 32767, 32767, 0, 0, 0);
      add_csr(CSR_ZERO_ANGLE, 20'h08000);
      add_csr(CSR_BAL_P_GAIN, 20'h0FFFF);
      add_csr(CSR_BAL_D_GAIN, 20'h0FFFF);
      add_csr(CSR_VEL_P_GAIN, 20'h0FFFF);
      add_csr(CSR_VEL_I_GAIN, 20'h0FFFF);
      add_tick(0, 0, 32767, 32767, -32768, -32768, 0, 0, 0);
      add_tick(0, 0, -32768, -32768, 32767, 32767, 0, 0, 0);
      // all gains zero: both terms vanish
      add_csr(CSR_ZERO_ANGLE, 20'h07FFF);
      add_csr(CSR_BAL_P_GAIN, 20'd0);
      add_csr(CSR_BAL_D_GAIN, 20'd0);
      add_csr(CSR_VEL_P_GAIN, 20'd0);
      add_csr(CSR_VEL_I_GAIN, 20'd0);
      add_tick(0, 0, -32768, 32767, 32767, 32767, 1, 0, 0);
   endtask

   // Random register set for one phase, extremes and reset values mixed in.
   task automatic shuffle_regs();
      logic [19:0] v;
      case ($urandom_range(0, 3))
         0: v = 20'h08000;
         1: v = 20'h07FFF;
         2: v = 20'($urandom_range(0, 4096)) - 20'd2048;
         default: v = 20'($urandom);
      endcase
      write_reg(CSR_ZERO_ANGLE, v & 20'h0FFFF);
      for (int g = 1; g <= 4; g++) begin
         case ($urandom_range(0, 4))
            0: v = 20'd0;
            1: v = 20'h0FFFF;
            2: v = 20'((g == 1) ? BAL_P_GAIN_RST : (g == 2) ? BAL_D_GAIN_RST :
                       (g == 3) ? VEL_P_GAIN_RST : VEL_I_GAIN_RST);
            3: v = 20'($urandom_range(0, 8192));
            default: v = 20'($urandom);
         endcase
         write_reg(bpc_csr_index_type'(g), v & 20'h0FFFF);
      end
      case ($urandom_range(0, 4))
         0: v = 20'd0;
         1: v = 20'hFFFFF;
         2: v = 20'($urandom_range(1, 2000));
         3: v = INT_LIMIT_RST;
         default: v = 20'($urandom);
      endcase
      write_reg(CSR_INT_LIMIT, v);
      case ($urandom_range(0, 4))
         0: v = 20'd0;
         1: v = 20'd127;
         2: v = 20'd100;
         3: v = 20'(OUT_LIMIT_RST);
         default: v = 20'($urandom_range(0, 127));
      endcase
      write_reg(CSR_OUT_LIMIT, v);
   endtask

   initial begin
      tick_type t;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.manual    = 1'b0;
      req_bus.stick_speed = '0;
      req_bus.tilt_angle  = '0;
      req_bus.tilt_rate   = '0;
      req_bus.count_left  = '0;
      req_bus.count_right = '0;
      pin_en            = 1'b0;
      pin_duty          = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      build_table();
      foreach (stim_table[i]) begin
         if (stim_table[i].kind == ROW_CSR)
            write_reg(stim_table[i].csr_idx, stim_table[i].csr_val);
         else
            send_tick(stim_table[i].tick, stim_table[i].pinned, stim_table[i].duty);
      end

      // random phases; half the ticks near the set-point so the loops stay unsaturated
      for (int p = 0; p < PHASES; p++) begin
         shuffle_regs();
         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            t.manual      = ($urandom_range(0, 99) < 15);
            t.stick_speed = 8'($urandom);
            if ($urandom_range(0, 1) == 0) begin
               t.tilt_angle  = 16'($urandom);
               t.tilt_rate   = 16'($urandom);
               t.count_left  = 16'($urandom);
               t.count_right = 16'($urandom);
            end else begin
               t.tilt_angle  = 16'(int'(cfg_zero_angle) + int'($urandom_range(0, 1024)) - 512);
               t.tilt_rate   = 16'(int'($urandom_range(0, 4000)) - 2000);
               t.count_left  = 16'(int'($urandom_range(0, 400)) - 200);
               t.count_right = 16'(int'($urandom_range(0, 400)) - 200);
            end
            send_tick(t, 1'b0, '0);
         end
      end

      // drain, then let the block settle before the final check
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (duty_expected.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (duty_expected.size() != 0) log_mismatch("missing beat", duty_expected[0], '0);

      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
